FILE: rtl/swfd_pkg.sv
// Shared types and constants for the sync word frame deframer.
package swfd_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [47:0] SYNC_RESET = 48'hEAFF99DEADFF;
	localparam logic [47:0] END_RESET  = 48'hEAFF99DEADAA;

	localparam logic CFG_SYNC = 1'b0;
	localparam logic CFG_END  = 1'b1;

	localparam logic [1:0] KIND_HDR   = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_EOF   = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	// Last byte position in a header and in a word (six bytes each)
	localparam logic [2:0] LAST_POS = 3'd5;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_HDR,
		ST_DATA,
		ST_END
	} stage_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       eob;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  app_id;
		logic [23:0] frame_len;
		logic [7:0]  mask;
		logic [7:0]  reserved_byte;
		logic [47:0] word;
		logic [23:0] word_index;
		logic        eof_ok;
	} result_t;

endpackage

FILE: rtl/sync_word_frame_deframer_core.sv
// Top level of the sync word frame deframer.
// Usage:
//   Slave stream s_*: one raw byte per transaction in s_tdata, s_tlast marks
//   the last byte of a capture buffer. Master stream m_*: one result per
//   transaction, m_tuser gives the kind (header, data word, end of frame,
//   frame abandoned), m_tdata the header fields, word, index and match flag.
//   Configuration channel cfg_*: index 0 writes the start word, index 1 the
//   end word; it is always ready. The user must write it only while the block
//   is idle; the block does not enforce this. Throughput is one byte per cycle
//   while the receiver does not stall, set by the parser consuming one byte
//   from the four-entry input queue each cycle; results are registered for m_*.
//   Reset clears the queue, the output register and the parser, which then
//   hunts for the start word; the patterns return to their defaults.
//   When the receiver stalls, the result holds in the output register, the
//   parser stops, and the queue absorbs up to four more bytes before
//   s_tready drops.
module sync_word_frame_deframer_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,     // [7:0] data_byte
	input  logic         s_tlast,     // end_of_buffer
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,     // app_id, frame_len, mask, reserved_byte,
	                                  // word, word_index, eof_ok, zero pad
	output logic [1:0]   m_tuser,     // [1:0] kind
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [47:0]  cfg_data
);

	swfd_pkg::item_t    in_item;
	swfd_pkg::item_t    q_item;
	swfd_pkg::result_t  res;
	logic               q_valid;
	logic               q_ready;

	assign in_item.data_byte = s_tdata;
	assign in_item.eob       = s_tlast;
	assign cfg_ready         = 1'b1;

	swfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	swfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {7'd0, res.eof_ok, res.word_index, res.word, res.reserved_byte,
		res.mask, res.frame_len, res.app_id};

	a_hdr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == swfd_pkg::KIND_HDR |-> m_tdata[120:48] == '0)
		else $error("header result carries word, index or flag");

	a_ok_only_eof: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != swfd_pkg::KIND_EOF |-> !m_tdata[120])
		else $error("match flag set outside end of frame");

	a_abort_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == swfd_pkg::KIND_ABORT |-> m_tdata[95:48] == '0)
		else $error("abandoned frame result carries a word");

endmodule

FILE: rtl/swfd_front.sv
// Front end: accepts stream bytes and queues them for the parser.
module swfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  swfd_pkg::item_t     in_item,
	output logic                q_valid,
	input  logic                q_ready,
	output swfd_pkg::item_t     q_item
);

	swfd_pkg::item_t                 mem_q [swfd_pkg::QDEPTH];
	logic [swfd_pkg::QAW-1:0]        wr_ptr_q;
	logic [swfd_pkg::QAW-1:0]        rd_ptr_q;
	logic [swfd_pkg::QAW:0]          count_q;
	logic                            push;
	logic                            pop;

	assign in_ready = (count_q != (swfd_pkg::QAW+1)'(swfd_pkg::QDEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

endmodule

FILE: rtl/swfd_parser.sv
// Back end: hunts for the start word, parses frames and registers results.
module swfd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [47:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  swfd_pkg::item_t     in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output swfd_pkg::result_t   out_res
);

	swfd_pkg::stage_t   stage_q, stage_n;
	logic [47:0]        sync_pat_q;
	logic [47:0]        end_pat_q;
	logic [39:0]        shift_q, shift_n;
	logic [2:0]         cnt_q, cnt_n;
	logic [7:0]         app_q, app_n;
	logic [23:0]        len_q, len_n;
	logic [7:0]         mask_q, mask_n;
	logic [7:0]         rsv_q, rsv_n;
	logic [23:0]        words_q, words_n;
	logic [47:0]        accum_q, accum_n;
	logic [47:0]        window;
	logic [47:0]        accum_sh;
	logic [23:0]        words_inc;
	logic               fire;
	logic               emit;
	logic               take;
	logic               valid_q;
	swfd_pkg::result_t  res_n;
	swfd_pkg::result_t  res_q;

	assign take      = !valid_q || out_ready;
	assign in_ready  = take;
	assign fire      = in_valid && take;
	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign window    = {shift_q, in_item.data_byte};
	assign accum_sh  = {accum_q[39:0], in_item.data_byte};
	assign words_inc = words_q + 24'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q    <= swfd_pkg::ST_HUNT;
			sync_pat_q <= swfd_pkg::SYNC_RESET;
			end_pat_q  <= swfd_pkg::END_RESET;
			shift_q    <= '0;
			cnt_q      <= '0;
			app_q      <= '0;
			len_q      <= '0;
			mask_q     <= '0;
			rsv_q      <= '0;
			words_q    <= '0;
			accum_q    <= '0;
			valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					swfd_pkg::CFG_SYNC: sync_pat_q <= cfg_data;
					swfd_pkg::CFG_END:  end_pat_q  <= cfg_data;
					default: ;
				endcase
			end
			if (fire) begin
				stage_q <= stage_n;
				shift_q <= shift_n;
				cnt_q   <= cnt_n;
				app_q   <= app_n;
				len_q   <= len_n;
				mask_q  <= mask_n;
				rsv_q   <= rsv_n;
				words_q <= words_n;
				accum_q <= accum_n;
			end
			if (take) valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res_n;
	end

	always_comb begin
		stage_n = stage_q;
		shift_n = shift_q;
		cnt_n   = cnt_q;
		app_n   = app_q;
		len_n   = len_q;
		mask_n  = mask_q;
		rsv_n   = rsv_q;
		words_n = words_q;
		accum_n = accum_q;
		emit    = 1'b0;
		res_n   = '0;

		unique case (stage_q)
			swfd_pkg::ST_HUNT: begin
				if (cnt_q == swfd_pkg::LAST_POS && window == sync_pat_q && !in_item.eob) begin
					stage_n = swfd_pkg::ST_HDR;
					cnt_n   = '0;
					shift_n = '0;
					app_n   = '0;
					len_n   = '0;
					mask_n  = '0;
					rsv_n   = '0;
					words_n = '0;
					accum_n = '0;
				end else if (in_item.eob) begin
					cnt_n   = '0;
					shift_n = '0;
				end else begin
					shift_n = window[39:0];
					if (cnt_q != swfd_pkg::LAST_POS) cnt_n = cnt_q + 3'd1;
				end
			end
			swfd_pkg::ST_HDR: begin
				case (cnt_q)
					3'd0:               app_n  = in_item.data_byte;
					3'd1, 3'd2, 3'd3:   len_n  = {len_q[15:0], in_item.data_byte};
					3'd4:               mask_n = in_item.data_byte;
					default:            rsv_n  = in_item.data_byte;
				endcase
				cnt_n = cnt_q + 3'd1;
				if (cnt_q == swfd_pkg::LAST_POS) begin
					cnt_n      = '0;
					accum_n    = '0;
					stage_n    = (len_q == '0) ? swfd_pkg::ST_END : swfd_pkg::ST_DATA;
					emit       = 1'b1;
					res_n.kind = swfd_pkg::KIND_HDR;
				end
			end
			default: begin
				// Data and end word share the byte assembly
				accum_n = accum_sh;
				cnt_n   = cnt_q + 3'd1;
				if (cnt_q == swfd_pkg::LAST_POS) begin
					cnt_n   = '0;
					accum_n = '0;
					emit    = 1'b1;
					if (stage_q == swfd_pkg::ST_DATA) begin
						res_n.kind       = swfd_pkg::KIND_DATA;
						res_n.word       = accum_sh;
						res_n.word_index = words_q;
						words_n          = words_inc;
						if (words_inc == len_q) stage_n = swfd_pkg::ST_END;
					end else begin
						res_n.kind       = swfd_pkg::KIND_EOF;
						res_n.word       = accum_sh;
						res_n.word_index = words_q;
						res_n.eof_ok     = (accum_sh == end_pat_q);
						stage_n          = swfd_pkg::ST_HUNT;
						shift_n          = '0;
					end
				end
			end
		endcase

		// Buffer end abandons a frame that this byte did not finish
		if (stage_q != swfd_pkg::ST_HUNT && in_item.eob && res_n.kind != swfd_pkg::KIND_EOF) begin
			emit             = 1'b1;
			res_n            = '0;
			res_n.kind       = swfd_pkg::KIND_ABORT;
			res_n.word_index = words_n;
			accum_n          = '0;
			stage_n          = swfd_pkg::ST_HUNT;
			cnt_n            = '0;
			shift_n          = '0;
		end

		res_n.app_id        = app_n;
		res_n.frame_len     = len_n;
		res_n.mask          = mask_n;
		res_n.reserved_byte = rsv_n;
	end

endmodule

FILE: tb/tb_sync_word_frame_deframer_core.sv
// Self-checking testbench for the sync word frame deframer core.
`timescale 1ns / 1ps

module tb_sync_word_frame_deframer_core;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned SETTLE      = 12;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_index;
	logic [47:0]  cfg_data;

	sync_word_frame_deframer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Stream bytes waiting to be sent and results still owed by the block
	swfd_pkg::item_t   byte_queue[$];
	swfd_pkg::result_t expected_results[$];

	// Deframer state as the testbench tracks it
	logic [47:0]      sync_word;
	logic [47:0]      end_word;
	logic [39:0]      hunt_window;
	swfd_pkg::stage_t stage;
	logic [3:0]       pos;
	logic [7:0]       hdr_app;
	logic [23:0]      hdr_len;
	logic [7:0]       hdr_mask;
	logic [7:0]       hdr_rsv;
	logic [23:0]      words_seen;
	logic [47:0]      accum;

	int unsigned errors;
	int unsigned bytes_pushed;
	int unsigned bytes_sent;
	int unsigned n_hdr, n_data, n_eof, n_eof_ok, n_abort, n_cfg;
	int unsigned quiet;
	int unsigned send_gap, recv_gap;
	bit          idle_on;
	bit          s_took;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic swfd_pkg::result_t frame_result(input logic [1:0] kind,
			input logic [47:0] w, input logic [23:0] idx, input logic ok);
		swfd_pkg::result_t r;
		r.kind          = kind;
		r.app_id        = hdr_app;
		r.frame_len     = hdr_len;
		r.mask          = hdr_mask;
		r.reserved_byte = hdr_rsv;
		r.word          = w;
		r.word_index    = idx;
		r.eof_ok        = ok;
		return r;
	endfunction

	function automatic void restart_hunt();
		stage       = swfd_pkg::ST_HUNT;
		pos         = '0;
		hunt_window = '0;
	endfunction

	// Advance the tracked deframer by one byte; return 1 when a result is produced
	function automatic bit deframe_byte(input logic [7:0] b, input logic eob,
			output swfd_pkg::result_t r);
		logic [47:0] window;
		bit          got;
		got = 1'b0;
		r   = '0;
		if (stage == swfd_pkg::ST_HUNT) begin
			window = {hunt_window, b};
			if (pos >= 4'd5 && window == sync_word && !eob) begin
				stage       = swfd_pkg::ST_HDR;
				pos         = '0;
				hunt_window = '0;
				hdr_app     = '0;
				hdr_len     = '0;
				hdr_mask    = '0;
				hdr_rsv     = '0;
				words_seen  = '0;
				accum       = '0;
			end else if (eob) begin
				restart_hunt();
			end else begin
				hunt_window = window[39:0];
				if (pos < 4'd5)
					pos++;
			end
			return 1'b0;
		end
		if (stage == swfd_pkg::ST_HDR) begin
			case (pos)
				4'd0: hdr_app = b;
				4'd1, 4'd2, 4'd3: hdr_len = {hdr_len[15:0], b};
				4'd4: hdr_mask = b;
				default: hdr_rsv = b;
			endcase
			pos++;
			if (pos >= 4'd6) begin
				pos   = '0;
				accum = '0;
				stage = (hdr_len == '0) ? swfd_pkg::ST_END : swfd_pkg::ST_DATA;
				r     = frame_result(swfd_pkg::KIND_HDR, '0, '0, 1'b0);
				got   = 1'b1;
			end
		end else begin
			accum = {accum[39:0], b};
			pos++;
			if (pos >= 4'd6) begin
				pos = '0;
				if (stage == swfd_pkg::ST_DATA) begin
					r   = frame_result(swfd_pkg::KIND_DATA, accum, words_seen, 1'b0);
					got = 1'b1;
					words_seen++;
					if (words_seen == hdr_len)
						stage = swfd_pkg::ST_END;
				end else begin
					// end word completes the frame, even on a buffer end
					r     = frame_result(swfd_pkg::KIND_EOF, accum, words_seen,
						accum == end_word);
					accum = '0;
					restart_hunt();
					return 1'b1;
				end
				accum = '0;
			end
		end
		if (eob) begin
			r     = frame_result(swfd_pkg::KIND_ABORT, '0, words_seen, 1'b0);
			accum = '0;
			restart_hunt();
			got   = 1'b1;
		end
		return got;
	endfunction

	// Sender: drive at the falling edge, hold a byte until its transaction completes
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_took)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 8);
				s_tvalid <= 1'b0;
			end else if (byte_queue.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= byte_queue[0].data_byte;
				s_tlast  <= byte_queue[0].eob;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		swfd_pkg::item_t   it;
		swfd_pkg::result_t r;
		s_took = s_tvalid && s_tready && arst_n;
		if (s_took) begin
			it = byte_queue.pop_front();
			bytes_sent++;
			if (deframe_byte(it.data_byte, it.eob, r))
				expected_results.push_back(r);
		end
	end

	// Receiver: stall in bursts while idle_on is set
	always @(negedge clk) begin
		if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			recv_gap = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic report_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		errors++;
		if (errors <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		swfd_pkg::result_t exp_r;
		swfd_pkg::result_t got_r;
		if (arst_n && m_tvalid && m_tready) begin
			got_r.kind          = m_tuser;
			got_r.app_id        = m_tdata[7:0];
			got_r.frame_len     = m_tdata[31:8];
			got_r.mask          = m_tdata[39:32];
			got_r.reserved_byte = m_tdata[47:40];
			got_r.word          = m_tdata[95:48];
			got_r.word_index    = m_tdata[119:96];
			got_r.eof_ok        = m_tdata[120];
			case (got_r.kind)
				swfd_pkg::KIND_HDR:   n_hdr++;
				swfd_pkg::KIND_DATA:  n_data++;
				swfd_pkg::KIND_EOF:   n_eof++;
				default:              n_abort++;
			endcase
			if (got_r.kind == swfd_pkg::KIND_EOF && got_r.eof_ok)
				n_eof_ok++;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result, kind %0d word %0h", $realtime,
						got_r.kind, got_r.word);
			end else begin
				exp_r = expected_results.pop_front();
				if (exp_r.kind != got_r.kind)
					report_field("kind", 64'(exp_r.kind), 64'(got_r.kind));
				if (exp_r.app_id != got_r.app_id)
					report_field("app_id", 64'(exp_r.app_id), 64'(got_r.app_id));
				if (exp_r.frame_len != got_r.frame_len)
					report_field("frame_len", 64'(exp_r.frame_len), 64'(got_r.frame_len));
				if (exp_r.mask != got_r.mask)
					report_field("mask", 64'(exp_r.mask), 64'(got_r.mask));
				if (exp_r.reserved_byte != got_r.reserved_byte)
					report_field("reserved_byte", 64'(exp_r.reserved_byte),
						64'(got_r.reserved_byte));
				if (exp_r.word != got_r.word)
					report_field("word", 64'(exp_r.word), 64'(got_r.word));
				if (exp_r.word_index != got_r.word_index)
					report_field("word_index", 64'(exp_r.word_index), 64'(got_r.word_index));
				if (exp_r.eof_ok != got_r.eof_ok)
					report_field("eof_ok", 64'(exp_r.eof_ok), 64'(got_r.eof_ok));
			end
		end
	end

	// Watchdog: end the run when no transaction completes for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("timeout: %0d results outstanding, %0d bytes unsent",
				expected_results.size(), byte_queue.size());
			$display("tb_sync_word_frame_deframer_core: errors");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic eob);
		swfd_pkg::item_t it;
		it.data_byte = b;
		it.eob       = eob;
		byte_queue.push_back(it);
		bytes_pushed++;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic push_sync(input int unsigned nbytes);
		for (int i = 5; i > 5 - int'(nbytes); i--)
			push_byte(sync_word[8*i +: 8], 1'b0);
	endtask

	// Start word, header, data words and end word; cut >= 0 stops the frame with
	// a buffer end on that byte after the start word
	task automatic push_frame(input logic [23:0] len, input bit good_end, input int cut,
			input logic [7:0] app, input logic [7:0] msk, input logic [7:0] rsv);
		logic [7:0]  hdr[6];
		logic [47:0] ew;
		longint      total;
		logic [7:0]  b;
		hdr = '{app, len[23:16], len[15:8], len[7:0], msk, rsv};
		ew  = good_end ? end_word : {16'($urandom), 32'($urandom)};
		total = 12 + 6 * longint'(len);
		push_sync(6);
		for (longint k = 0; k < total; k++) begin
			if (k < 6)
				b = hdr[k];
			else if (k < total - 6)
				b = rand_byte();
			else
				b = ew[8*(total - 1 - k) +: 8];
			push_byte(b, cut >= 0 && k == cut);
			if (cut >= 0 && k == cut)
				break;
		end
	endtask

	task automatic write_reg(input logic idx, input logic [47:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == swfd_pkg::CFG_SYNC)
			sync_word = value;
		else
			end_word = value;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (byte_queue.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned target);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		int          total;
		stop_at = bytes_pushed + target;
		while (bytes_pushed < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
				total = 12 + 6 * int'(len);
				// sometimes let the buffer end fall on the last end word byte
				push_frame(24'(len), $urandom_range(0, 3) != 0,
					($urandom_range(0, 9) == 0) ? total - 1 : -1,
					rand_byte(), rand_byte(), rand_byte());
			end else if (pick < 70) begin
				len = $urandom_range(0, 4);
				push_frame(24'(len), 1'b1, int'($urandom_range(0, 12 + 6 * len - 2)),
					rand_byte(), rand_byte(), rand_byte());
			end else if (pick < 75) begin
				// huge announced length, always abandoned early
				push_frame(24'($urandom_range(5, 24'hFFFFFF)), 1'b1,
					int'($urandom_range(0, 23)),
					rand_byte(), rand_byte(), rand_byte());
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 8))
					push_byte(rand_byte(), $urandom_range(0, 15) == 0);
			end else begin
				// false start: part of the start word, then something else
				push_sync($urandom_range(1, 5));
				push_byte(rand_byte(), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = swfd_pkg::CFG_SYNC;
		cfg_data  = '0;
		errors = 0;
		bytes_pushed = 0;
		bytes_sent = 0;
		n_hdr = 0; n_data = 0; n_eof = 0; n_eof_ok = 0; n_abort = 0; n_cfg = 0;
		quiet = 0;
		send_gap = 0;
		recv_gap = 0;
		s_took = 1'b0;
		idle_on = 1'b1;
		sync_word = swfd_pkg::SYNC_RESET;
		end_word  = swfd_pkg::END_RESET;
		hdr_app = '0; hdr_len = '0; hdr_mask = '0; hdr_rsv = '0;
		words_seen = '0;
		accum = '0;
		restart_hunt();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a zero length frame whose end word carries the buffer end,
		// then a start word ending on a buffer end, which must be ignored
		push_frame(24'd0, 1'b1, 11, 8'hFF, 8'h00, 8'hFF);
		push_sync(5);
		push_byte(sync_word[7:0], 1'b1);
		run_random(330);
		drain();

		write_reg(swfd_pkg::CFG_SYNC, 48'hFFFF_FFFF_FFFF);
		write_reg(swfd_pkg::CFG_END, 48'h0);
		run_random(350);
		drain();

		// All-zero start word: the short window decides when zeros match
		write_reg(swfd_pkg::CFG_SYNC, 48'h0);
		write_reg(swfd_pkg::CFG_END, 48'hFFFF_FFFF_FFFF);
		repeat (8)
			push_byte(8'h00, 1'b0);
		run_random(340);
		drain();

		write_reg(swfd_pkg::CFG_SYNC, {16'($urandom), 32'($urandom)});
		write_reg(swfd_pkg::CFG_END, {16'($urandom), 32'($urandom)});
		run_random(400);
		drain();

		write_reg(swfd_pkg::CFG_SYNC, swfd_pkg::SYNC_RESET);
		write_reg(swfd_pkg::CFG_END, swfd_pkg::END_RESET);
		idle_on = 1'b0;
		run_random(400);
		drain();

		if (expected_results.size() != 0)
			errors++;
		$display("sent %0d bytes over %0d register writes; got %0d headers, %0d data words",
			bytes_sent, n_cfg, n_hdr, n_data);
		$display("frame ends %0d (%0d matching), abandoned frames %0d, mismatches %0d",
			n_eof, n_eof_ok, n_abort, errors);
		if (errors == 0)
			$display("tb_sync_word_frame_deframer_core: clean");
		else
			$display("tb_sync_word_frame_deframer_core: errors");
		$finish;
	end

endmodule

FILE: files.f
rtl/swfd_pkg.sv
rtl/swfd_front.sv
rtl/swfd_parser.sv
rtl/sync_word_frame_deframer_core.sv
tb/tb_sync_word_frame_deframer_core.sv
